### hdl/smma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smma_pkg;

  // field widths fixed by the interface
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned ACT_W = 3;
  localparam int unsigned POS_W = 4;
  localparam int unsigned DATA_W = 48;
  localparam int unsigned AB_W = 16;
  localparam int unsigned PROD_W = 2 * AB_W;

  localparam int unsigned MAX_SIZE_DEFAULT = 16;
  localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = 5'd16;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOAD_A = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_B = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD_C = 3'd2;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ_C = 3'd4;

  // microprogram step addresses
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_INIT = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CELL = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LOAD_ACC = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MUL = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ACC = 3'd4;
  localparam logic [STEP_W-1:0] STEP_STORE = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NEXT_ROW = 3'd6;
  localparam logic [STEP_W-1:0] STEP_END = 3'd7;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER  = 3'd0,
    COND_ALWAYS = 3'd1,
    COND_N_ZERO = 3'd2,
    COND_K_MORE = 3'd3,
    COND_J_MORE = 3'd4,
    COND_I_MORE = 3'd5
  } cond_t;

  // one control word
  typedef struct packed {
    logic clr_ij;
    logic clr_k;
    logic inc_k;
    logic inc_j;
    logic clr_j_inc_i;
    logic rd_c;
    logic rd_ab;
    logic ld_acc;
    logic ld_prod;
    logic add_acc;
    logic wr_c;
    logic done;
    cond_t cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    w.cond = COND_NEVER;
    unique case (step)
      STEP_INIT: begin
        w.clr_ij = 1'b1;
        w.cond = COND_N_ZERO;
        w.target = STEP_END;
      end
      STEP_CELL: begin
        w.clr_k = 1'b1;
        w.rd_c = 1'b1;
      end
      STEP_LOAD_ACC: begin
        w.ld_acc = 1'b1;
        w.rd_ab = 1'b1;
      end
      STEP_MUL: begin
        w.ld_prod = 1'b1;
        w.inc_k = 1'b1;
      end
      STEP_ACC: begin
        w.add_acc = 1'b1;
        w.rd_ab = 1'b1;
        w.cond = COND_K_MORE;
        w.target = STEP_MUL;
      end
      STEP_STORE: begin
        w.wr_c = 1'b1;
        w.inc_j = 1'b1;
        w.cond = COND_J_MORE;
        w.target = STEP_CELL;
      end
      STEP_NEXT_ROW: begin
        w.clr_j_inc_i = 1'b1;
        w.cond = COND_I_MORE;
        w.target = STEP_CELL;
      end
      STEP_END: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hdl/square_matrix_multiply_accumulate.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                                            | handshake
// ----------+----------------------------------------------------+----------------------
// command   | start, busy, action, row, column, element_value    | start & !busy
// result    | strobe, read_value                                 | strobe, one cycle
// config    | config_valid, config_ready, matrix_size            | valid & ready
//
// loads and reads take one transaction per cycle while busy is low; a read result
// strobes the cycle after its transaction. compute keeps busy high until the
// microcoded sequencer ends; it runs two steps per multiply-accumulate on the shared
// multiplier and single-ported matrix memories. rst is synchronous and clears control
// state and the size register (16); matrix storage is not cleared. the receiver cannot
// stall results; config is taken only while busy is low.

module square_matrix_multiply_accumulate
  import smma_pkg::*;
#(
  parameter int unsigned MAX_SIZE = MAX_SIZE_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [ACT_W-1:0]         action,
  input  wire logic [POS_W-1:0]         row,
  input  wire logic [POS_W-1:0]         column,
  input  wire logic signed [DATA_W-1:0] element_value,
  output logic                          strobe,
  output logic signed [DATA_W-1:0]      read_value,
  input  wire logic                     config_valid,
  output logic                          config_ready,
  input  wire logic [SIZE_W-1:0]        matrix_size
);

  localparam int unsigned AW = $clog2(MAX_SIZE);
  localparam int unsigned CW = $clog2(MAX_SIZE + 1);
  localparam int unsigned DEPTH = 1 << (2 * AW);

  // storage
  logic signed [AB_W-1:0] left_mem [DEPTH];
  logic signed [AB_W-1:0] right_mem [DEPTH];
  logic signed [DATA_W-1:0] acc_mem [DEPTH];

  logic [SIZE_W-1:0] size_reg;
  logic [CW-1:0] n_reg;
  logic [CW-1:0] i_cnt, j_cnt, k_cnt;
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ucode_t uc;
  logic jump;

  logic signed [AB_W-1:0] a_rd, b_rd;
  logic signed [DATA_W-1:0] c_rd;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W:0] sum;
  logic signed [DATA_W-1:0] sum_sat;
  logic out_inside;

  logic accept;
  logic pos_ok;
  logic [2*AW-1:0] pos_addr;
  logic [2*AW-1:0] a_addr, b_addr, c_addr;
  logic [CW-1:0] n_eff;

  // command decode
  assign accept = start && !busy;
  assign pos_ok = (32'(row) < MAX_SIZE) && (32'(column) < MAX_SIZE);
  assign pos_addr = {AW'(row), AW'(column)};
  assign n_eff = (32'(size_reg) > MAX_SIZE) ? CW'(MAX_SIZE) : CW'(size_reg);
  assign config_ready = !busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= MATRIX_SIZE_RESET;
    end else if (config_valid && config_ready) begin
      size_reg <= matrix_size;
    end
  end

  // microcode fetch and jump decision
  assign uc = ucode_rom(pc);

  always_comb begin
    unique case (uc.cond)
      COND_NEVER:  jump = 1'b0;
      COND_ALWAYS: jump = 1'b1;
      COND_N_ZERO: jump = (n_reg == '0);
      COND_K_MORE: jump = (k_cnt != n_reg);
      COND_J_MORE: jump = (j_cnt != n_reg - CW'(1));
      COND_I_MORE: jump = (i_cnt != n_reg - CW'(1));
      default:     jump = 1'b0;
    endcase
    pc_next = jump ? uc.target : pc + STEP_W'(1);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= STEP_INIT;
    end else if (busy) begin
      if (uc.done) begin
        busy <= 1'b0;
      end
      pc <= pc_next;
    end else if (accept && action == ACT_COMPUTE) begin
      busy <= 1'b1;
      pc <= STEP_INIT;
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (accept && action == ACT_COMPUTE) begin
      n_reg <= n_eff;
    end
    if (busy) begin
      if (uc.clr_ij) begin
        i_cnt <= '0;
        j_cnt <= '0;
      end
      if (uc.clr_k) begin
        k_cnt <= '0;
      end
      if (uc.inc_k) begin
        k_cnt <= k_cnt + CW'(1);
      end
      if (uc.inc_j) begin
        j_cnt <= j_cnt + CW'(1);
      end
      if (uc.clr_j_inc_i) begin
        j_cnt <= '0;
        i_cnt <= i_cnt + CW'(1);
      end
    end
  end

  // compute addresses
  assign a_addr = {i_cnt[AW-1:0], k_cnt[AW-1:0]};
  assign b_addr = {k_cnt[AW-1:0], j_cnt[AW-1:0]};
  assign c_addr = busy ? {i_cnt[AW-1:0], j_cnt[AW-1:0]} : pos_addr;

  // left and right matrix memories
  always_ff @(posedge clk) begin
    if (accept && pos_ok && action == ACT_LOAD_A) begin
      left_mem[pos_addr] <= element_value[AB_W-1:0];
    end
    if (busy && uc.rd_ab) begin
      a_rd <= left_mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos_ok && action == ACT_LOAD_B) begin
      right_mem[pos_addr] <= element_value[AB_W-1:0];
    end
    if (busy && uc.rd_ab) begin
      b_rd <= right_mem[b_addr];
    end
  end

  // accumulator matrix memory
  always_ff @(posedge clk) begin
    if (accept && pos_ok && action == ACT_LOAD_C) begin
      acc_mem[c_addr] <= element_value;
    end else if (busy && uc.wr_c) begin
      acc_mem[c_addr] <= acc;
    end
    if ((busy && uc.rd_c) || (accept && action == ACT_READ_C)) begin
      c_rd <= acc_mem[c_addr];
    end
  end

  // saturating accumulate
  assign sum = {acc[DATA_W-1], acc} + (DATA_W + 1)'(prod);
  assign sum_sat = (sum[DATA_W] == sum[DATA_W-1]) ? sum[DATA_W-1:0] :
                   {sum[DATA_W], {(DATA_W - 1){~sum[DATA_W]}}};

  // multiply and accumulate registers
  always_ff @(posedge clk) begin
    if (busy && uc.ld_prod) begin
      prod <= a_rd * b_rd;
    end
    if (busy && uc.ld_acc) begin
      acc <= c_rd;
    end else if (busy && uc.add_acc) begin
      acc <= sum_sat;
    end
  end

  // read result
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= accept && action == ACT_READ_C;
    end
    if (accept && action == ACT_READ_C) begin
      out_inside <= pos_ok;
    end
  end

  assign read_value = out_inside ? c_rd : '0;

endmodule

`default_nettype wire
